[design/rmseod_pkg.sv]
package rmseod_pkg;

  localparam int MAX_SAMPLES = 8192;
  localparam int MAX_WINDOW  = 1024;

  // field widths
  localparam int SMP_IN_W   = 16;
  localparam int Q15_W      = 16;
  localparam int IDX_W      = 13;
  localparam int WLEN_W     = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // internal widths
  localparam int SMP_W  = $clog2(MAX_SAMPLES + 1);
  localparam int LEN_W  = $clog2(MAX_WINDOW + 1);
  // a full window of full-scale samples sums to exactly 2^40
  localparam int SUM_W  = 41;
  localparam int MUL_W  = 16;
  localparam int PROD_W = 2 * MUL_W;
  localparam int RAD_W  = 32;
  localparam int ROOT_W = RAD_W / 2;

  localparam logic [Q15_W-1:0] ONE_Q15 = 16'h8000;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SLOPE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BOOST_RISE    = 2'd2;

  localparam logic [WLEN_W-1:0] WINDOW_LENGTH_RST = 11'd240;
  localparam logic [Q15_W-1:0]  MIN_SLOPE_RST     = 16'd328;
  localparam logic [Q15_W-1:0]  BOOST_RISE_RST    = 16'd1638;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

[design/rmseod_mul.sv]
// Shift-add multiplier, one multiplier bit per cycle.
module rmseod_mul import rmseod_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [MUL_W-1:0]  a_i,
  input  logic [MUL_W-1:0]  b_i,
  output unit_stat_t        stat_o,
  output logic [PROD_W-1:0] prod_o
);

  localparam int CNT_W = $clog2(MUL_W);

  logic              busy_q;
  logic              done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [MUL_W-1:0]  a_q;
  logic [PROD_W-1:0] p_q;
  logic [MUL_W:0]    add;

  // upper half plus multiplicand when the current low bit is set
  assign add = {1'b0, p_q[PROD_W-1:MUL_W]} + (p_q[0] ? {1'b0, a_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(MUL_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      p_q <= {{MUL_W{1'b0}}, b_i};
    end else if (busy_q) begin
      p_q <= {add, p_q[MUL_W-1:1]};
    end
  end

  assign stat_o = '{busy: busy_q, done: done_q};
  assign prod_o = p_q;

endmodule

[design/rmseod_div.sv]
// Restoring divider, one quotient bit per cycle.
module rmseod_div import rmseod_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SUM_W-1:0] num_i,
  input  logic [LEN_W-1:0] den_i,
  output unit_stat_t       stat_o,
  output logic [SUM_W-1:0] quot_o
);

  localparam int CNT_W = $clog2(SUM_W);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [SUM_W-1:0] num_q;
  logic [LEN_W-1:0] den_q;
  logic [LEN_W-1:0] rem_q;
  logic [LEN_W:0]   rem_sh;
  logic [LEN_W:0]   rem_sub;
  logic             q_bit;

  assign rem_sh  = {rem_q, num_q[SUM_W-1]};
  assign q_bit   = rem_sh >= {1'b0, den_q};
  assign rem_sub = rem_sh - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(SUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // quotient bits shift in where the dividend shifts out
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[SUM_W-2:0], q_bit};
      rem_q <= q_bit ? rem_sub[LEN_W-1:0] : rem_sh[LEN_W-1:0];
    end
  end

  assign stat_o = '{busy: busy_q, done: done_q};
  assign quot_o = num_q;

endmodule

[design/rmseod_sqrt.sv]
// Integer square root, two radicand bits and one root bit per cycle.
module rmseod_sqrt import rmseod_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [RAD_W-1:0]  rad_i,
  output unit_stat_t        stat_o,
  output logic [ROOT_W-1:0] root_o
);

  localparam int CNT_W = $clog2(ROOT_W);
  localparam int REM_W = ROOT_W + 2;

  logic              busy_q;
  logic              done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [RAD_W-1:0]  rad_q;
  logic [REM_W-1:0]  rem_q;
  logic [ROOT_W-1:0] root_q;
  logic [REM_W+1:0]  rem_sh;
  logic [REM_W+1:0]  trial;
  logic [REM_W+1:0]  rem_sub;
  logic              r_bit;

  assign rem_sh  = {rem_q, rad_q[RAD_W-1 -: 2]};
  assign trial   = {2'b00, root_q, 2'b01};
  assign r_bit   = rem_sh >= trial;
  assign rem_sub = rem_sh - trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(ROOT_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // remainder never exceeds twice the partial root
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
      rem_q  <= r_bit ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
      root_q <= {root_q[ROOT_W-2:0], r_bit};
    end
  end

  assign stat_o = '{busy: busy_q, done: done_q};
  assign root_o = root_q;

endmodule

[design/rms_envelope_onset_detector.sv]
// A sample that closes no window is squared in the serial multiplier.
// A sample that closes a window then goes through the serial divide and the serial root.
// The sample marked last adds the onset index multiply, plus a divide when
// the confidence boost runs through the divider; a sample past the block limit is not squared.
// One item at a time; a held result that is stalled holds off the next item.
// Reset is asynchronous, active low: block state clears, registers take their defaults.
module rms_envelope_onset_detector import rmseod_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic signed [SMP_IN_W-1:0]  sample_i,
  input  logic                        last_sample_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [IDX_W-1:0]            onset_index_o,
  output logic [Q15_W-1:0]            sharpness_o,
  output logic [Q15_W-1:0]            confidence_o,
  input  logic                        cfg_we_i,
  input  logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [CFG_DATA_W-1:0]       cfg_wdata_i
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SQR  = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_SQRT = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;
  localparam logic [2:0] ST_FMUL = 3'd5;
  localparam logic [2:0] ST_FDIV = 3'd6;
  localparam logic [2:0] ST_OUT  = 3'd7;

  localparam logic [LEN_W-1:0] BOOST_DEN = LEN_W'(10);

  logic [2:0] state_q, state_d;

  logic [WLEN_W-1:0] window_length_q;
  logic [Q15_W-1:0]  min_slope_q;
  logic [Q15_W-1:0]  boost_rise_q;

  logic [SUM_W-1:0] sum_q;
  logic [LEN_W-1:0] fill_q;
  logic [SMP_W-1:0] count_q;
  logic [SMP_W-1:0] samples_q;
  logic [Q15_W-1:0] prev_q;
  logic [Q15_W-1:0] pprev_q;
  logic [Q15_W-1:0] best_rise_q;
  logic [SMP_W-1:0] best_win_q;
  logic             best_boost_q;
  logic             out_valid_q;

  logic             last_q;
  logic [IDX_W-1:0] idx_q;
  logic [Q15_W-1:0] sharp_q;
  logic [Q15_W-1:0] conf_q;
  logic [IDX_W-1:0] onset_out_q;
  logic [Q15_W-1:0] sharp_out_q;
  logic [Q15_W-1:0] conf_out_q;

  // unit hook-up
  logic              mul_start, div_start, sqrt_start;
  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [SUM_W-1:0]  div_num;
  logic [LEN_W-1:0]  div_den;
  unit_stat_t        mul_st, div_st, sqrt_st;
  logic [PROD_W-1:0] mul_prod;
  logic [SUM_W-1:0]  div_quot;
  logic [ROOT_W-1:0] sqrt_root;

  logic               in_acc;
  logic               out_load;
  logic [LEN_W-1:0]   len_eff;
  logic [MUL_W-1:0]   mag;
  logic               room;
  logic [SUM_W-1:0]   sum_new;
  logic [LEN_W-1:0]   fill_new;
  logic               win_close;
  logic [Q15_W-1:0]   rise;
  logic               take_rise;
  logic               boost_new;
  logic [PROD_W-1:0]  idx_sel;
  logic [Q15_W+3:0]   sharp10;
  logic [Q15_W+4:0]   conf20;
  logic [Q15_W-1:0]   sharp_sat;
  logic [Q15_W-1:0]   conf_sat;
  logic [Q15_W+2:0]   conf12;
  logic               conf_ok;
  logic               boost_path;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_load   = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    if (window_length_q == '0) begin
      len_eff = LEN_W'(1);
    end else if (32'(window_length_q) > MAX_WINDOW) begin
      len_eff = LEN_W'(MAX_WINDOW);
    end else begin
      len_eff = LEN_W'(window_length_q);
    end
  end

  // 16-bit negate gives 0x8000 for the most negative sample
  assign mag = sample_i[SMP_IN_W-1] ? MUL_W'(-sample_i) : MUL_W'(sample_i);
  assign room = samples_q < SMP_W'(MAX_SAMPLES);

  assign sum_new   = sum_q + SUM_W'(mul_prod);
  assign fill_new  = fill_q + 1'b1;
  assign win_close = fill_new >= len_eff;

  // rise into the window just closed
  assign rise      = sqrt_root - prev_q;
  assign take_rise = (count_q != '0) && (sqrt_root > prev_q) && (rise > best_rise_q);
  assign boost_new = (count_q >= SMP_W'(2)) && (prev_q > pprev_q) &&
                     ((prev_q - pprev_q) > boost_rise_q);

  // end-of-block scores
  assign idx_sel = ((samples_q != '0) && (mul_prod >= PROD_W'(samples_q))) ?
                   PROD_W'(samples_q - 1'b1) : mul_prod;
  assign sharp10 = ((Q15_W+4)'(best_rise_q) << 3) + ((Q15_W+4)'(best_rise_q) << 1);
  assign conf20  = {sharp10, 1'b0};
  assign sharp_sat = (sharp10 > (Q15_W+4)'(ONE_Q15)) ? ONE_Q15 : sharp10[Q15_W-1:0];
  assign conf_sat  = (conf20 > (Q15_W+5)'(ONE_Q15)) ? ONE_Q15 : conf20[Q15_W-1:0];
  // times 12, then divided by ten in the shared divider
  assign conf12  = ((Q15_W+3)'(conf_sat) << 3) + ((Q15_W+3)'(conf_sat) << 2);
  assign conf_ok = best_rise_q > min_slope_q;
  assign boost_path = conf_ok && best_boost_q;

  always_comb begin
    state_d    = state_q;
    mul_start  = 1'b0;
    div_start  = 1'b0;
    sqrt_start = 1'b0;
    mul_a      = mag;
    mul_b      = mag;
    div_num    = sum_new;
    div_den    = fill_new;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (room) begin
            mul_start = 1'b1;
            state_d   = ST_SQR;
          end else if (last_sample_i) begin
            state_d = ST_FIN;
          end
        end
      end
      ST_SQR: begin
        if (mul_st.done) begin
          if (win_close) begin
            div_start = 1'b1;
            state_d   = ST_DIV;
          end else if (last_q) begin
            state_d = ST_FIN;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_DIV: begin
        if (div_st.done) begin
          sqrt_start = 1'b1;
          state_d    = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (sqrt_st.done) begin
          state_d = last_q ? ST_FIN : ST_IDLE;
        end
      end
      ST_FIN: begin
        mul_start = 1'b1;
        mul_a     = MUL_W'(best_win_q);
        mul_b     = MUL_W'(len_eff);
        state_d   = ST_FMUL;
      end
      ST_FMUL: begin
        div_num = SUM_W'(conf12);
        div_den = BOOST_DEN;
        if (mul_st.done) begin
          if (boost_path) begin
            div_start = 1'b1;
            state_d   = ST_FDIV;
          end else begin
            state_d = ST_OUT;
          end
        end
      end
      ST_FDIV: begin
        if (div_st.done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      window_length_q <= WINDOW_LENGTH_RST;
      min_slope_q     <= MIN_SLOPE_RST;
      boost_rise_q    <= BOOST_RISE_RST;
      sum_q           <= '0;
      fill_q          <= '0;
      count_q         <= '0;
      samples_q       <= '0;
      prev_q          <= '0;
      pprev_q         <= '0;
      best_rise_q     <= '0;
      best_win_q      <= '0;
      best_boost_q    <= 1'b0;
      out_valid_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_WINDOW_LENGTH: window_length_q <= cfg_wdata_i[WLEN_W-1:0];
          CFG_MIN_SLOPE:     min_slope_q     <= cfg_wdata_i[Q15_W-1:0];
          CFG_BOOST_RISE:    boost_rise_q    <= cfg_wdata_i[Q15_W-1:0];
          default: ;
        endcase
      end
      if ((state_q == ST_SQR) && mul_st.done) begin
        sum_q     <= sum_new;
        fill_q    <= fill_new;
        samples_q <= samples_q + 1'b1;
      end
      if ((state_q == ST_SQRT) && sqrt_st.done) begin
        if (take_rise) begin
          best_rise_q  <= rise;
          best_win_q   <= count_q - 1'b1;
          best_boost_q <= boost_new;
        end
        pprev_q <= prev_q;
        prev_q  <= sqrt_root;
        count_q <= count_q + 1'b1;
        sum_q   <= '0;
        fill_q  <= '0;
      end
      if (out_load) begin
        out_valid_q  <= 1'b1;
        sum_q        <= '0;
        fill_q       <= '0;
        count_q      <= '0;
        samples_q    <= '0;
        prev_q       <= '0;
        pprev_q      <= '0;
        best_rise_q  <= '0;
        best_win_q   <= '0;
        best_boost_q <= 1'b0;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      last_q <= last_sample_i;
    end
    if ((state_q == ST_FMUL) && mul_st.done) begin
      idx_q   <= idx_sel[IDX_W-1:0];
      sharp_q <= sharp_sat;
      conf_q  <= conf_ok ? conf_sat : '0;
    end
    if ((state_q == ST_FDIV) && div_st.done) begin
      conf_q <= (div_quot > SUM_W'(ONE_Q15)) ? ONE_Q15 : div_quot[Q15_W-1:0];
    end
    if (out_load) begin
      onset_out_q <= idx_q;
      sharp_out_q <= sharp_q;
      conf_out_q  <= conf_q;
    end
  end

  rmseod_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .stat_o  (mul_st),
    .prod_o  (mul_prod)
  );

  rmseod_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .stat_o  (div_st),
    .quot_o  (div_quot)
  );

  rmseod_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (div_quot[RAD_W-1:0]),
    .stat_o  (sqrt_st),
    .root_o  (sqrt_root)
  );

  assign out_valid_o   = out_valid_q;
  assign onset_index_o = onset_out_q;
  assign sharpness_o   = sharp_out_q;
  assign confidence_o  = conf_out_q;

  a_idle_units: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !(mul_st.busy || div_st.busy || sqrt_st.busy))
    else $error("serial unit busy while taking a new item");

  a_one_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({mul_st.busy, div_st.busy, sqrt_st.busy}))
    else $error("more than one serial unit running");

  a_sample_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    samples_q <= SMP_W'(MAX_SAMPLES))
    else $error("sample count past block limit");

  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == ST_OUT)
    else $error("result raised outside the output state");

endmodule

[test/rmseod_onset_checker.sv]
module rmseod_onset_checker import rmseod_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic [SMP_IN_W-1:0]   sample_i,
  input  logic                  last_sample_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic [IDX_W-1:0]      onset_index_i,
  input  logic [Q15_W-1:0]      sharpness_i,
  input  logic [Q15_W-1:0]      confidence_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output int                    fail_count_o,
  output int                    pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [Q15_W-1:0] sharp;
    logic [Q15_W-1:0] conf;
  } onset_rpt_t;

  onset_rpt_t onset_reports_q[$];
  int         mismatches;

  // register copies
  logic [WLEN_W-1:0] wlen_r;
  logic [Q15_W-1:0]  slope_r;
  logic [Q15_W-1:0]  boost_r;

  // block state
  longint unsigned   sq_acc;
  logic [10:0]       fill;
  logic [13:0]       win_cnt;
  logic [13:0]       taken;
  logic [Q15_W-1:0]  e_prev;
  logic [Q15_W-1:0]  e_prev2;
  logic [Q15_W-1:0]  rise_best;
  logic [IDX_W-1:0]  win_best;
  logic              boost_best;

  function automatic logic [Q15_W-1:0] root_floor(input longint unsigned v);
    longint unsigned rem;
    longint unsigned root;
    longint unsigned bitv;
    rem  = v;
    root = 0;
    bitv = 64'h4000_0000_0000_0000;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem  = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root[Q15_W-1:0];
  endfunction

  task automatic clear_block();
    sq_acc     = 0;
    fill       = '0;
    win_cnt    = '0;
    taken      = '0;
    e_prev     = '0;
    e_prev2    = '0;
    rise_best  = '0;
    win_best   = '0;
    boost_best = 1'b0;
  endtask

  task automatic close_window();
    logic [Q15_W-1:0] e;
    logic [Q15_W-1:0] rise;
    e = root_floor(sq_acc / 64'(fill));
    if (win_cnt >= 1 && e > e_prev) begin
      rise = e - e_prev;
      // strictly greater, so the earliest of equal rises is kept
      if (rise > rise_best) begin
        rise_best  = rise;
        win_best   = IDX_W'(win_cnt - 1);
        boost_best = (win_cnt >= 2) && (e_prev > e_prev2) && ((e_prev - e_prev2) > boost_r);
      end
    end
    e_prev2 = e_prev;
    e_prev  = e;
    win_cnt = win_cnt + 1;
    sq_acc  = 0;
    fill    = '0;
  endtask

  task automatic advance_envelope(input logic [SMP_IN_W-1:0] s, input logic last);
    int unsigned     len;
    longint unsigned mag;
    longint unsigned span;
    longint unsigned sharp;
    longint unsigned conf;
    onset_rpt_t      rpt;
    len = (wlen_r == 0) ? 1 : ((wlen_r > MAX_WINDOW) ? MAX_WINDOW : int'(wlen_r));
    if (taken < MAX_SAMPLES) begin
      mag    = s[SMP_IN_W-1] ? 64'd65536 - 64'(s) : 64'(s);
      taken  = taken + 1;
      sq_acc = sq_acc + mag * mag;
      fill   = fill + 1;
      if (fill >= len) close_window();
    end
    if (last) begin
      span = 64'(win_best) * 64'(len);
      if (taken != 0 && span >= 64'(taken)) span = 64'(taken) - 1;
      sharp = 64'(rise_best) * 10;
      if (sharp > 64'(ONE_Q15)) sharp = 64'(ONE_Q15);
      conf = 0;
      if (rise_best > slope_r) begin
        conf = 64'(rise_best) * 20;
        if (conf > 64'(ONE_Q15)) conf = 64'(ONE_Q15);
        if (boost_best) begin
          conf = conf * 12 / 10;
          if (conf > 64'(ONE_Q15)) conf = 64'(ONE_Q15);
        end
      end
      rpt.idx   = span[IDX_W-1:0];
      rpt.sharp = sharp[Q15_W-1:0];
      rpt.conf  = conf[Q15_W-1:0];
      onset_reports_q.push_back(rpt);
      clear_block();
    end
  endtask

  task automatic compare_report();
    onset_rpt_t want;
    if (onset_reports_q.size() == 0) begin
      if (mismatches < 10)
        $display("unexpected onset result: index %0d sharpness %0d confidence %0d",
                 onset_index_i, sharpness_i, confidence_i);
      mismatches++;
    end else begin
      want = onset_reports_q.pop_front();
      if (want.idx !== onset_index_i || want.sharp !== sharpness_i ||
          want.conf !== confidence_i) begin
        if (mismatches < 10)
          $display("onset mismatch (exp/got): index %0d/%0d sharpness %0d/%0d confidence %0d/%0d",
                   want.idx, onset_index_i, want.sharp, sharpness_i,
                   want.conf, confidence_i);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_r  = WINDOW_LENGTH_RST;
      slope_r = MIN_SLOPE_RST;
      boost_r = BOOST_RISE_RST;
      clear_block();
      onset_reports_q.delete();
      mismatches = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // an output never belongs to the item accepted at the same edge
      if (out_valid_i && !out_stall_i) compare_report();
      if (in_valid_i && !in_stall_i) advance_envelope(sample_i, last_sample_i);
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_WINDOW_LENGTH: wlen_r  = cfg_wdata_i[WLEN_W-1:0];
          CFG_MIN_SLOPE:     slope_r = cfg_wdata_i[Q15_W-1:0];
          CFG_BOOST_RISE:    boost_r = cfg_wdata_i[Q15_W-1:0];
          default: ;
        endcase
      end
      fail_count_o <= mismatches;
      pending_o    <= onset_reports_q.size();
    end
  end

endmodule

[test/tb_rms_envelope_onset_detector.sv]
module tb_rms_envelope_onset_detector;
  import rmseod_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_valid    = 1'b0;
  logic                  in_stall;
  logic [SMP_IN_W-1:0]   sample      = '0;
  logic                  last_sample = 1'b0;
  logic                  out_valid;
  logic                  out_stall   = 1'b0;
  logic [IDX_W-1:0]      onset_index;
  logic [Q15_W-1:0]      sharpness;
  logic [Q15_W-1:0]      confidence;
  logic                  cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index   = CFG_WINDOW_LENGTH;
  logic [CFG_DATA_W-1:0] cfg_wdata   = '0;

  int fails;
  int pending;
  int idle_pct  = 0;
  int stall_pct = 0;
  int sent      = 0;
  int wl_cur    = WINDOW_LENGTH_RST;

  rms_envelope_onset_detector dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .sample_i      (sample),
    .last_sample_i (last_sample),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .onset_index_o (onset_index),
    .sharpness_o   (sharpness),
    .confidence_o  (confidence),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_wdata_i   (cfg_wdata)
  );

  rmseod_onset_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .sample_i      (sample),
    .last_sample_i (last_sample),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .onset_index_i (onset_index),
    .sharpness_i   (sharpness),
    .confidence_i  (confidence),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_wdata_i   (cfg_wdata),
    .fail_count_o  (fails),
    .pending_o     (pending)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

  // receiver back-pressure
  initial begin
    forever begin
      @(negedge clk);
      out_stall = ($urandom_range(0, 99) < stall_pct);
    end
  end

  function automatic int eff_len();
    if (wl_cur == 0) return 1;
    if (wl_cur > MAX_WINDOW) return MAX_WINDOW;
    return wl_cur;
  endfunction

  task automatic send_sample(input int s, input logic last);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid    = 1'b1;
    sample      = s[SMP_IN_W-1:0];
    last_sample = last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val[CFG_DATA_W-1:0];
    if (idx == CFG_WINDOW_LENGTH) wl_cur = val & 'h7FF;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // block must be quiet before a register write
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  function automatic int pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) return 0;
    if (r < 12) return $urandom_range(1025, 2047);
    if (r < 15) return MAX_WINDOW;
    if (r < 25) return $urandom_range(7, 48);
    return $urandom_range(1, 6);
  endfunction

  function automatic int pick_q15();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 0;
    if (r < 18) return 'hFFFF;
    if (r < 28) return ONE_Q15;
    if (r < 60) return $urandom_range(0, 3000);
    return $urandom_range(0, 65535);
  endfunction

  // exact mode: samples are +-amp, so the window energy is amp itself
  function automatic int pick_amp(input bit exact);
    int r;
    r = $urandom_range(0, 99);
    if (exact) return (r < 10) ? 32768 : 500 * $urandom_range(0, 8);
    if (r < 15) return 0;
    if (r < 35) return $urandom_range(0, 2000);
    if (r < 50) return 32768;
    return $urandom_range(0, 32768);
  endfunction

  function automatic int gen_sample(input int amp, input bit exact);
    int v;
    if (exact) begin
      if (amp >= 32768) return -32768;
      return $urandom_range(0, 1) ? amp : -amp;
    end
    v = int'($urandom_range(0, 2 * amp)) - amp;
    return (v > 32767) ? 32767 : v;
  endfunction

  task automatic random_block();
    int n;
    int len_eff;
    int amp;
    int split;
    bit exact;
    if ($urandom_range(0, 1)) write_reg(CFG_WINDOW_LENGTH, pick_length());
    if ($urandom_range(0, 2) == 0) write_reg(CFG_MIN_SLOPE, pick_q15());
    if ($urandom_range(0, 2) == 0) write_reg(CFG_BOOST_RISE, pick_q15());
    if ($urandom_range(0, 19) == 0) write_reg(CFG_UNUSED, $urandom_range(0, 65535));
    len_eff = eff_len();
    if (len_eff > 48) n = $urandom_range(1, 20);
    else if (len_eff > 6) n = $urandom_range(1, 3 * len_eff);
    else n = $urandom_range(1, 12 * len_eff);
    split = (n > 1 && $urandom_range(0, 5) == 0) ? $urandom_range(1, n - 1) : 0;
    exact = ($urandom_range(0, 3) == 0);
    amp   = 0;
    for (int i = 0; i < n; i++) begin
      if (split != 0 && i == split) begin
        // length change in the middle of a block
        settle();
        write_reg(CFG_WINDOW_LENGTH, $urandom_range(1, 6));
        len_eff = eff_len();
      end
      if (i == 0 || $urandom_range(1, len_eff) == 1) amp = pick_amp(exact);
      send_sample(gen_sample(amp, exact), i == n - 1);
    end
    settle();
  endtask

  // runs past the sample limit with the widest windows; the first window is full scale
  task automatic long_block();
    int amp;
    amp = 0;
    write_reg(CFG_WINDOW_LENGTH, MAX_WINDOW);
    for (int i = 0; i < MAX_SAMPLES + 8; i++) begin
      if (i % MAX_WINDOW == 0) amp = (i == 0) ? 32768 : $urandom_range(0, 32767);
      send_sample($urandom_range(0, 1) ? amp : -amp, i == MAX_SAMPLES + 7);
    end
    settle();
  endtask

  initial begin
    int target;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset lengths: block far shorter than one window
    send_sample(32767, 1'b0);
    send_sample(-32768, 1'b0);
    send_sample(0, 1'b1);
    settle();
    send_sample(-1, 1'b1);
    settle();

    write_reg(CFG_WINDOW_LENGTH, 1);
    write_reg(CFG_MIN_SLOPE, 0);
    write_reg(CFG_BOOST_RISE, 0);
    send_sample(0, 1'b0);
    send_sample(4, 1'b0);
    send_sample(4, 1'b0);
    send_sample(100, 1'b0);
    send_sample(-32768, 1'b0);
    send_sample(32767, 1'b1);
    settle();

    // zero length acts as one; equal rises keep the first
    write_reg(CFG_WINDOW_LENGTH, 0);
    write_reg(CFG_MIN_SLOPE, 'hFFFF);
    write_reg(CFG_BOOST_RISE, 'hFFFF);
    send_sample(1000, 1'b0);
    send_sample(0, 1'b0);
    send_sample(1000, 1'b0);
    send_sample(0, 1'b0);
    send_sample(1000, 1'b1);
    settle();

    write_reg(CFG_WINDOW_LENGTH, 2047);
    send_sample(12345, 1'b0);
    send_sample(-12345, 1'b1);
    settle();

    // shrink the length with a window part filled
    write_reg(CFG_WINDOW_LENGTH, 4);
    write_reg(CFG_MIN_SLOPE, ONE_Q15);
    write_reg(CFG_BOOST_RISE, BOOST_RISE_RST);
    send_sample(2000, 1'b0);
    send_sample(-2000, 1'b0);
    send_sample(2000, 1'b0);
    settle();
    write_reg(CFG_WINDOW_LENGTH, 2);
    send_sample(100, 1'b0);
    send_sample(3000, 1'b0);
    send_sample(3000, 1'b0);
    settle();
    write_reg(CFG_WINDOW_LENGTH, 3);
    send_sample(5, 1'b1);
    settle();

    long_block();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 68; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 68; end
        default: begin idle_pct = 9; stall_pct = 9; end
      endcase
      target = sent + 400;
      while (sent < target) random_block();
    end

    while (pending != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[filelist.f]
design/rmseod_pkg.sv
design/rmseod_mul.sv
design/rmseod_div.sv
design/rmseod_sqrt.sv
design/rms_envelope_onset_detector.sv
test/rmseod_onset_checker.sv
test/tb_rms_envelope_onset_detector.sv
